@@ design/ttrr_pkg.sv @@
// Shared types, constants and helpers for the round-robin thread table.
// Used by every module of the block except ttrr_ram; depends on nothing else.
`default_nettype none

package ttrr_pkg;

    localparam int SLOTS     = 16;
    localparam int TID_BITS  = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int TID_EXT_W = (TID_BITS > 16) ? TID_BITS : 16;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [TID_BITS-1:0]  tid_t;
    typedef logic [TID_EXT_W-1:0] tid_ext_t;
    typedef logic [15:0]          out_tid_t;
    typedef logic [3:0]           out_slot_t;

    localparam slot_t LAST_SLOT   = slot_t'(SLOTS - 1);
    localparam slot_t FIRST_UPPER = slot_t'(1);
    localparam cnt_t  SCAN_ALL    = cnt_t'(SLOTS);
    localparam cnt_t  SCAN_UPPER  = cnt_t'(SLOTS - 1);
    localparam cnt_t  CNT_ONE     = cnt_t'(1);
    localparam tid_t  TID_ONE     = tid_t'(1);
    localparam tid_t  TID_MAX     = '1;

    // Join ids that do not fit in TID_BITS are rejected.
    localparam logic [15:0] JOIN_MASK =
        (TID_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TID_BITS) - 32'd1);

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_YIELD  = 2'd1,
        FN_JOIN   = 2'd2,
        FN_EXIT   = 2'd3
    } func_e;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_SLOT   = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_WAIT      = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        SS_FREE     = 2'd0,
        SS_RUNNABLE = 2'd1,
        SS_RUNNING  = 2'd2,
        SS_ZOMBIE   = 2'd3
    } slot_state_e;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CUR_RD,
        SQ_CUR_CHK,
        SQ_SCAN,
        SQ_WR_A,
        SQ_WR_B,
        SQ_DONE
    } seq_state_e;

    typedef struct packed {
        slot_state_e st;
        tid_t        tid;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        slot_t       rd_addr;
        logic        we;
        slot_t       wr_addr;
        slot_entry_t wr_data;
    } mem_req_t;

    typedef struct packed {
        status_e   status;
        out_tid_t  new_tid;
        logic      switched;
        out_slot_t prev_slot;
        out_slot_t run_slot;
        out_tid_t  run_tid;
    } res_t;

    function automatic slot_t slot_inc(slot_t s);
        return (s == LAST_SLOT) ? '0 : s + slot_t'(1);
    endfunction

    function automatic tid_t join_want(logic [15:0] j);
        tid_ext_t w;
        w = tid_ext_t'(j);
        return tid_t'(w);
    endfunction

    function automatic tid_t tid_step(tid_t t);
        return (t == TID_MAX) ? TID_ONE : t + TID_ONE;
    endfunction

endpackage

`default_nettype wire

@@ design/ttrr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ttrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/ttrr_slot_mem.sv @@
// Slot table storage: one RAM of slot entries plus per-entry written flags
// so that untouched entries read back as their reset value. Uses ttrr_pkg, ttrr_ram.
`default_nettype none

module ttrr_slot_mem (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ttrr_pkg::mem_req_t     req,
    output ttrr_pkg::slot_entry_t       rd_ent
);

    logic [ttrr_pkg::SLOTS-1:0]   valid_reg;
    logic                         rd_valid_reg;
    logic                         rd_zero_reg;
    logic [ttrr_pkg::ENTRY_W-1:0] ram_q;
    ttrr_pkg::slot_entry_t        ram_ent;
    ttrr_pkg::slot_entry_t        rst_ent;

    ttrr_ram #(
        .WIDTH (ttrr_pkg::ENTRY_W),
        .DEPTH (ttrr_pkg::SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.we),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
        rd_valid_reg <= valid_reg[req.rd_addr];
        rd_zero_reg  <= (req.rd_addr == '0);
    end

    // Slot 0 comes out of reset running; every other slot is free.
    always_comb begin
        ram_ent     = ttrr_pkg::slot_entry_t'(ram_q);
        rst_ent.st  = rd_zero_reg ? ttrr_pkg::SS_RUNNING : ttrr_pkg::SS_FREE;
        rst_ent.tid = '0;
        rd_ent      = rd_valid_reg ? ram_ent : rst_ent;
    end

endmodule

`default_nettype wire

@@ design/ttrr_seq.sv @@
// Operation sequencer: scans the slot table one entry per cycle and writes
// back the updated entries. Uses ttrr_pkg; drives ttrr_slot_mem.
`default_nettype none

module ttrr_seq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ttrr_pkg::func_e       in_func,
    input  wire logic [15:0]           in_join_tid,
    output logic                       res_valid,
    input  wire logic                  res_take,
    output ttrr_pkg::res_t             res,
    output ttrr_pkg::mem_req_t         mem_req,
    input  wire ttrr_pkg::slot_entry_t mem_rd
);

    ttrr_pkg::seq_state_e  state_reg, state_next;
    ttrr_pkg::func_e       func_reg, func_next;
    ttrr_pkg::status_e     status_reg, status_next;
    ttrr_pkg::tid_t        want_reg, want_next;
    ttrr_pkg::tid_t        new_tid_reg, new_tid_next;
    ttrr_pkg::tid_t        run_tid_reg, run_tid_next;
    ttrr_pkg::tid_t        cnt_reg, cnt_next;
    ttrr_pkg::slot_t       cur_reg, cur_next;
    ttrr_pkg::slot_t       prev_reg, prev_next;
    ttrr_pkg::slot_t       iss_idx_reg, iss_idx_next;
    ttrr_pkg::cnt_t        iss_left_reg, iss_left_next;
    ttrr_pkg::slot_t       chk_idx_reg, chk_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  chk_last_reg, chk_last_next;
    ttrr_pkg::slot_t       fnd_idx_reg, fnd_idx_next;
    ttrr_pkg::slot_entry_t fnd_ent_reg, fnd_ent_next;
    ttrr_pkg::slot_entry_t cur_ent_reg, cur_ent_next;
    logic                  yphase_reg, yphase_next;

    logic join_ok;
    logic scan_hit;
    logic scan_miss;

    assign join_ok = (in_join_tid != 16'd0) &&
                     ((in_join_tid & ttrr_pkg::JOIN_MASK) == in_join_tid);

    // Yield, exit and a waiting join look for a runnable slot, create for a free
    // one, and join for any non-free slot, zombie or live, holding the wanted id.
    always_comb begin
        if (yphase_reg) begin
            scan_hit = (mem_rd.st == ttrr_pkg::SS_RUNNABLE);
        end else if (func_reg == ttrr_pkg::FN_CREATE) begin
            scan_hit = (mem_rd.st == ttrr_pkg::SS_FREE);
        end else begin
            scan_hit = (mem_rd.st != ttrr_pkg::SS_FREE) && (mem_rd.tid == want_reg);
        end
        scan_hit  = scan_hit && chk_vld_reg;
        scan_miss = chk_vld_reg && chk_last_reg && !scan_hit;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttrr_pkg::SQ_IDLE: begin
                if (in_valid) begin
                    unique case (in_func)
                        ttrr_pkg::FN_CREATE: state_next = ttrr_pkg::SQ_SCAN;
                        ttrr_pkg::FN_JOIN:
                            state_next = join_ok ? ttrr_pkg::SQ_SCAN : ttrr_pkg::SQ_DONE;
                        default: state_next = ttrr_pkg::SQ_CUR_RD;
                    endcase
                end
            end
            ttrr_pkg::SQ_CUR_RD:  state_next = ttrr_pkg::SQ_CUR_CHK;
            ttrr_pkg::SQ_CUR_CHK: state_next = ttrr_pkg::SQ_SCAN;
            ttrr_pkg::SQ_SCAN: begin
                if (scan_hit) begin
                    if (!yphase_reg && func_reg == ttrr_pkg::FN_JOIN &&
                        mem_rd.st != ttrr_pkg::SS_ZOMBIE) begin
                        state_next = ttrr_pkg::SQ_CUR_RD;
                    end else begin
                        state_next = ttrr_pkg::SQ_WR_A;
                    end
                end else if (scan_miss) begin
                    state_next = ttrr_pkg::SQ_DONE;
                end
            end
            ttrr_pkg::SQ_WR_A: begin
                if (yphase_reg && cur_ent_reg.st == ttrr_pkg::SS_RUNNING) begin
                    state_next = ttrr_pkg::SQ_WR_B;
                end else begin
                    state_next = ttrr_pkg::SQ_DONE;
                end
            end
            ttrr_pkg::SQ_WR_B: state_next = ttrr_pkg::SQ_DONE;
            ttrr_pkg::SQ_DONE: begin
                if (res_take) begin
                    state_next = ttrr_pkg::SQ_IDLE;
                end
            end
            default: state_next = ttrr_pkg::SQ_IDLE;
        endcase
    end

    always_comb begin
        func_next     = func_reg;
        status_next   = status_reg;
        want_next     = want_reg;
        new_tid_next  = new_tid_reg;
        run_tid_next  = run_tid_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        iss_idx_next  = iss_idx_reg;
        iss_left_next = iss_left_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        chk_last_next = chk_last_reg;
        fnd_idx_next  = fnd_idx_reg;
        fnd_ent_next  = fnd_ent_reg;
        cur_ent_next  = cur_ent_reg;
        yphase_next   = yphase_reg;

        mem_req.rd_addr = iss_idx_reg;
        mem_req.we      = 1'b0;
        mem_req.wr_addr = fnd_idx_reg;
        mem_req.wr_data = fnd_ent_reg;

        in_ready  = (state_reg == ttrr_pkg::SQ_IDLE);
        res_valid = (state_reg == ttrr_pkg::SQ_DONE);

        res.status    = status_reg;
        res.new_tid   = ttrr_pkg::out_tid_t'(new_tid_reg);
        res.switched  = (cur_reg != prev_reg);
        res.prev_slot = ttrr_pkg::out_slot_t'(prev_reg);
        res.run_slot  = ttrr_pkg::out_slot_t'(cur_reg);
        res.run_tid   = ttrr_pkg::out_tid_t'(run_tid_reg);

        case (state_reg)
            ttrr_pkg::SQ_IDLE: begin
                if (in_valid) begin
                    func_next     = in_func;
                    prev_next     = cur_reg;
                    want_next     = ttrr_pkg::join_want(in_join_tid);
                    new_tid_next  = '0;
                    yphase_next   = (in_func == ttrr_pkg::FN_YIELD) ||
                                    (in_func == ttrr_pkg::FN_EXIT);
                    status_next   = (in_func == ttrr_pkg::FN_JOIN && !join_ok) ?
                                    ttrr_pkg::STS_NOT_FOUND : ttrr_pkg::STS_OK;
                    iss_idx_next  = ttrr_pkg::FIRST_UPPER;
                    iss_left_next = ttrr_pkg::SCAN_UPPER;
                end
            end
            ttrr_pkg::SQ_CUR_RD: begin
                mem_req.rd_addr = cur_reg;
            end
            ttrr_pkg::SQ_CUR_CHK: begin
                cur_ent_next = mem_rd;
                // Exit turns the running slot into a zombie before the yield.
                if (func_reg == ttrr_pkg::FN_EXIT) begin
                    cur_ent_next.st = ttrr_pkg::SS_ZOMBIE;
                    mem_req.we      = 1'b1;
                    mem_req.wr_addr = cur_reg;
                    mem_req.wr_data = '{st: ttrr_pkg::SS_ZOMBIE, tid: mem_rd.tid};
                end
                iss_idx_next  = ttrr_pkg::slot_inc(cur_reg);
                iss_left_next = ttrr_pkg::SCAN_ALL;
            end
            ttrr_pkg::SQ_SCAN: begin
                chk_idx_next = iss_idx_reg;
                if (iss_left_reg != '0) begin
                    iss_idx_next  = ttrr_pkg::slot_inc(iss_idx_reg);
                    iss_left_next = iss_left_reg - ttrr_pkg::CNT_ONE;
                    chk_vld_next  = 1'b1;
                    chk_last_next = (iss_left_reg == ttrr_pkg::CNT_ONE);
                end
                if (scan_hit) begin
                    chk_vld_next = 1'b0;
                    fnd_idx_next = chk_idx_reg;
                    fnd_ent_next = mem_rd;
                    if (!yphase_reg && func_reg == ttrr_pkg::FN_JOIN &&
                        mem_rd.st != ttrr_pkg::SS_ZOMBIE) begin
                        status_next = ttrr_pkg::STS_WAIT;
                        yphase_next = 1'b1;
                    end
                end else if (scan_miss) begin
                    chk_vld_next = 1'b0;
                    if (!yphase_reg) begin
                        status_next = (func_reg == ttrr_pkg::FN_CREATE) ?
                                      ttrr_pkg::STS_NO_SLOT : ttrr_pkg::STS_NOT_FOUND;
                    end
                end
            end
            ttrr_pkg::SQ_WR_A: begin
                mem_req.we      = 1'b1;
                mem_req.wr_addr = fnd_idx_reg;
                if (yphase_reg) begin
                    mem_req.wr_data = '{st: ttrr_pkg::SS_RUNNING, tid: fnd_ent_reg.tid};
                    cur_next        = fnd_idx_reg;
                    run_tid_next    = fnd_ent_reg.tid;
                end else if (func_reg == ttrr_pkg::FN_CREATE) begin
                    mem_req.wr_data = '{st: ttrr_pkg::SS_RUNNABLE, tid: cnt_reg};
                    new_tid_next    = cnt_reg;
                    cnt_next        = ttrr_pkg::tid_step(cnt_reg);
                    if (fnd_idx_reg == cur_reg) begin
                        run_tid_next = cnt_reg;
                    end
                end else begin
                    mem_req.wr_data = '{st: ttrr_pkg::SS_FREE, tid: '0};
                    if (fnd_idx_reg == cur_reg) begin
                        run_tid_next = '0;
                    end
                end
            end
            ttrr_pkg::SQ_WR_B: begin
                // The slot that was running goes back into the runnable pool.
                mem_req.we      = 1'b1;
                mem_req.wr_addr = prev_reg;
                mem_req.wr_data = '{st: ttrr_pkg::SS_RUNNABLE, tid: cur_ent_reg.tid};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttrr_pkg::SQ_IDLE;
            cur_reg     <= '0;
            cnt_reg     <= ttrr_pkg::TID_ONE;
            run_tid_reg <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            cnt_reg     <= cnt_next;
            run_tid_reg <= run_tid_next;
            chk_vld_reg <= chk_vld_next;
        end
        func_reg     <= func_next;
        status_reg   <= status_next;
        want_reg     <= want_next;
        new_tid_reg  <= new_tid_next;
        prev_reg     <= prev_next;
        iss_idx_reg  <= iss_idx_next;
        iss_left_reg <= iss_left_next;
        chk_idx_reg  <= chk_idx_next;
        chk_last_reg <= chk_last_next;
        fnd_idx_reg  <= fnd_idx_next;
        fnd_ent_reg  <= fnd_ent_next;
        cur_ent_reg  <= cur_ent_next;
        yphase_reg   <= yphase_next;
    end

endmodule

`default_nettype wire

@@ design/thread_table_round_robin.sv @@
// Top level of the round-robin thread table: handshake ports and the result
// output register. Uses ttrr_pkg, ttrr_seq and ttrr_slot_mem.
`default_nettype none

//  channel  | direction | ports                                            | handshake
//  ---------+-----------+--------------------------------------------------+----------------
//  s_       | in        | s_func, s_join_tid                               | s_valid/s_ready
//  m_       | out       | m_status, m_new_tid, m_switched, m_prev_slot,    | m_valid/m_ready
//           |           | m_run_slot, m_run_tid                            |
//
// One operation word is processed at a time. The slot table lives in a RAM with
// registered read data, and the scan walks it one slot per cycle with a read in
// flight. Reset is synchronous and active low; after it slot 0 is running and
// the next id is 1. No clearing pass is needed, so the block is ready at once.
// A finished result waits in the output register while the next word is
// accepted and worked on; only a second result is held back until m_ready.

module thread_table_round_robin (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_join_tid,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_new_tid,
    output logic             m_switched,
    output logic [3:0]       m_prev_slot,
    output logic [3:0]       m_run_slot,
    output logic [15:0]      m_run_tid
);

    ttrr_pkg::mem_req_t    mem_req;
    ttrr_pkg::slot_entry_t mem_rd;
    ttrr_pkg::res_t        seq_res;
    logic                  seq_res_valid;
    logic                  res_take;

    ttrr_pkg::res_t        out_reg;
    logic                  m_valid_reg;

    // The sequencer does all the table work; the top only buffers results.
    ttrr_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_func     (ttrr_pkg::func_e'(s_func)),
        .in_join_tid (s_join_tid),
        .res_valid   (seq_res_valid),
        .res_take    (res_take),
        .res         (seq_res),
        .mem_req     (mem_req),
        .mem_rd      (mem_rd)
    );

    ttrr_slot_mem u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_ent  (mem_rd)
    );

    // A new result moves in when the output register is empty or being drained.
    assign res_take = seq_res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_take) begin
            out_reg <= seq_res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_reg.status;
    assign m_new_tid   = out_reg.new_tid;
    assign m_switched  = out_reg.switched;
    assign m_prev_slot = out_reg.prev_slot;
    assign m_run_slot  = out_reg.run_slot;
    assign m_run_tid   = out_reg.run_tid;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the round-robin thread table, top module tb.
// Depends on ttrr_pkg for the operation, status and slot-state codes and on
// the thread_table_round_robin block; it needs no other file.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttrr_pkg::*;

    // Number of random operation words that follow the directed table.
    localparam int RANDOM_WORDS = 1080;
    // Cycles of quiet after the last result; covers a join that must yield.
    localparam int DRAIN_CYCLES = 80;
    // Receiver holds m_ready low this long once, so the block backs up.
    localparam int HOLD_CYCLES  = 500;

    // Expected results that can be read straight off the reset state.
    // Nothing moved: slot 0 still running with id 0.
    localparam res_t R_IDLE0 = res_t'({STS_OK, 16'h0000, 1'b0, 4'h0, 4'h0, 16'h0000});
    // Join rejected while slot 0 runs.
    localparam res_t R_BAD0  = res_t'({STS_NOT_FOUND, 16'h0000, 1'b0, 4'h0, 4'h0, 16'h0000});
    // First create after reset hands out id 1 without a switch.
    localparam res_t R_FIRST = res_t'({STS_OK, 16'h0001, 1'b0, 4'h0, 4'h0, 16'h0000});
    // Create with every slot from 1 upward taken.
    localparam res_t R_FULL  = res_t'({STS_NO_SLOT, 16'h0000, 1'b0, 4'h0, 4'h0, 16'h0000});

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [15:0] s_join_tid;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_new_tid;
    logic        m_switched;
    logic [3:0]  m_prev_slot;
    logic [3:0]  m_run_slot;
    logic [15:0] m_run_tid;

    thread_table_round_robin i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_join_tid  (s_join_tid),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_new_tid   (m_new_tid),
        .m_switched  (m_switched),
        .m_prev_slot (m_prev_slot),
        .m_run_slot  (m_run_slot),
        .m_run_tid   (m_run_tid)
    );

    // One line of the directed table. When has_fixed is set the result is
    // typed in by hand; otherwise the scheduler shadow below supplies it.
    typedef struct {
        func_e       op;
        logic [15:0] join_id;
        bit          has_fixed;
        res_t        fixed_res;
    } dir_row_t;

    dir_row_t    dir_table [$];
    res_t        pending_results [$];   // results owed by the block, oldest first
    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned burst_left    = 0;

    // Shadow copy of the scheduler: slot table, running slot and id counter.
    slot_state_e shadow_state [SLOTS];
    tid_t        shadow_tid   [SLOTS];
    slot_t       shadow_run;
    tid_t        shadow_next_id;

    // Free-running clock, 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs somewhere. The slowest legal run is
    // well under 2 ms, so this leaves plenty of margin.
    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    // Put the shadow into the post-reset state: slot 0 running with id 0,
    // every other slot free, and the next id to hand out is 1.
    task automatic shadow_reset();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_state[i] = SS_FREE;
            shadow_tid[i]   = '0;
        end
        shadow_state[0] = SS_RUNNING;
        shadow_run      = '0;
        shadow_next_id  = tid_t'(1);
    endtask

    // Round-robin dispatch: search starts at the slot after the running one
    // and wraps. A running slot steps back to runnable; a zombie stays a
    // zombie. With nothing runnable the table is left alone.
    function automatic void shadow_dispatch();
        slot_t idx;
        idx = shadow_run;
        for (int n = 0; n < SLOTS; n++) begin
            idx = (idx == LAST_SLOT) ? slot_t'(0) : idx + slot_t'(1);
            if (shadow_state[idx] == SS_RUNNABLE) begin
                if (shadow_state[shadow_run] == SS_RUNNING)
                    shadow_state[shadow_run] = SS_RUNNABLE;
                shadow_state[idx] = SS_RUNNING;
                shadow_run = idx;
                return;
            end
        end
    endfunction

    // Apply one operation word to the shadow and return the result word the
    // block must produce for it.
    function automatic res_t schedule_op(func_e op, logic [15:0] join_id);
        res_t  r;
        slot_t was_running;
        int    hit;
        was_running = shadow_run;
        r.status    = STS_OK;
        r.new_tid   = '0;
        hit         = -1;
        case (op)
            FN_CREATE: begin
                // Lowest free slot from 1 upward; slot 0 is never reused.
                for (int i = 1; i < SLOTS; i++) begin
                    if (hit < 0 && shadow_state[i] == SS_FREE)
                        hit = i;
                end
                if (hit < 0) begin
                    r.status = STS_NO_SLOT;
                end else begin
                    shadow_tid[hit]   = shadow_next_id;
                    shadow_state[hit] = SS_RUNNABLE;
                    r.new_tid         = 16'(shadow_next_id);
                    // The id counter skips zero when it wraps.
                    shadow_next_id = (shadow_next_id == TID_MAX) ? tid_t'(1)
                                                                 : shadow_next_id + tid_t'(1);
                end
            end
            FN_YIELD: begin
                shadow_dispatch();
            end
            FN_JOIN: begin
                // Id zero, or an id too wide for the table, is rejected outright.
                if (join_id == '0 || 16'(tid_t'(join_id)) != join_id) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    for (int i = 1; i < SLOTS; i++) begin
                        if (hit < 0 && shadow_state[i] != SS_FREE
                                && shadow_tid[i] == tid_t'(join_id))
                            hit = i;
                    end
                    if (hit < 0) begin
                        r.status = STS_NOT_FOUND;
                    end else if (shadow_state[hit] == SS_ZOMBIE) begin
                        shadow_state[hit] = SS_FREE;
                        shadow_tid[hit]   = '0;
                    end else begin
                        // Target still alive: give up the slot and retry later.
                        shadow_dispatch();
                        r.status = STS_WAIT;
                    end
                end
            end
            FN_EXIT: begin
                shadow_state[shadow_run] = SS_ZOMBIE;
                shadow_dispatch();
            end
        endcase
        r.switched  = (shadow_run != was_running);
        r.prev_slot = 4'(was_running);
        r.run_slot  = 4'(shadow_run);
        r.run_tid   = 16'(shadow_tid[shadow_run]);
        return r;
    endfunction

    // Choose a join target from the current table. Zombies are favored so
    // that slots get recycled and creates keep succeeding; live threads give
    // the waiting case; the rest is zero or an arbitrary 16-bit id.
    function automatic logic [15:0] pick_join_id();
        slot_t       zombies [$];
        slot_t       alive   [$];
        int unsigned pick;
        for (int i = 1; i < SLOTS; i++) begin
            if (shadow_state[i] == SS_ZOMBIE)
                zombies.push_back(slot_t'(i));
            else if (shadow_state[i] != SS_FREE)
                alive.push_back(slot_t'(i));
        end
        pick = $urandom_range(0, 9);
        if (pick <= 4 && zombies.size() != 0)
            return 16'(shadow_tid[zombies[$urandom_range(0, zombies.size() - 1)]]);
        if (pick <= 6 && alive.size() != 0)
            return 16'(shadow_tid[alive[$urandom_range(0, alive.size() - 1)]]);
        if (pick == 7)
            return '0;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic add_row(func_e op, logic [15:0] join_id, bit has_fixed, res_t fixed_res);
        dir_row_t row;
        row.op        = op;
        row.join_id   = join_id;
        row.has_fixed = has_fixed;
        row.fixed_res = fixed_res;
        dir_table.push_back(row);
    endtask

    // Offer one word and hold it until the block takes it. The shadow is
    // updated at the accepting edge, so the next word is picked from the
    // table as the block will see it. Bursts of back-to-back words alternate
    // with random gaps; a gap is waited out on the clock before the next word,
    // so s_valid is never lowered and raised in the same step.
    task automatic send_word(func_e op, logic [15:0] join_id, bit has_fixed, res_t fixed_res);
        res_t        predicted;
        int unsigned gap;
        s_valid    <= 1'b1;
        s_func     <= op;
        s_join_tid <= join_id;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = schedule_op(op, join_id);
        pending_results.push_back(has_fixed ? fixed_res : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: m_ready follows a pattern that changes every stretch, from
    // always ready through random and sparse acceptance. Once, after a few
    // hundred results, it holds off for a long stretch while the sender keeps
    // offering, so the output register and the operation in flight fill up
    // and s_ready must drop. Exactly one assignment to m_ready per edge.
    initial begin
        int unsigned pattern;
        int unsigned stretch_left;
        int unsigned hold_left;
        bit          hold_done;
        stretch_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        pattern      = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stretch_left == 0) begin
                pattern      = $urandom_range(0, 3);
                stretch_left = $urandom_range(10, 150);
            end
            stretch_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                case (pattern)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker. Outputs are read at the edge, before the block's own
    // updates land, so each accepted word is compared with the oldest entry
    // still owed.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d run_slot %0d",
                       m_status, m_run_slot);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",    16'(want.status),    16'(m_status));
                check_field("new_tid",   want.new_tid,        m_new_tid);
                check_field("switched",  16'(want.switched),  16'(m_switched));
                check_field("prev_slot", 16'(want.prev_slot), 16'(m_prev_slot));
                check_field("run_slot",  16'(want.run_slot),  16'(m_run_slot));
                check_field("run_tid",   want.run_tid,        m_run_tid);
            end
        end
    end

    // Main sequence: reset, directed table, random operations, drain, verdict.
    initial begin
        func_e       op;
        logic [15:0] join_id;
        int unsigned roll;

        s_valid    <= 1'b0;
        s_func     <= FN_CREATE;
        s_join_tid <= '0;
        aresetn    <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        shadow_reset();
        @(posedge aclk);

        // Directed table. It starts from the reset state, so the first rows
        // can be written down by hand.
        // A yield with nothing runnable changes nothing.
        add_row(FN_YIELD,  16'h0000, 1'b1, R_IDLE0);
        // Join of id zero, of the largest id, and of an id nobody holds.
        add_row(FN_JOIN,   16'h0000, 1'b1, R_BAD0);
        add_row(FN_JOIN,   16'hFFFF, 1'b1, R_BAD0);
        add_row(FN_JOIN,   16'h0001, 1'b1, R_BAD0);
        // Exit with nothing runnable: slot 0 turns zombie but keeps running.
        add_row(FN_EXIT,   16'h0000, 1'b1, R_IDLE0);
        // First create gets slot 1 and id 1; fourteen more fill the table.
        add_row(FN_CREATE, 16'h0000, 1'b1, R_FIRST);
        for (int i = 0; i < 14; i++)
            add_row(FN_CREATE, 16'h0000, 1'b0, R_IDLE0);
        // Table full: create must fail and change nothing.
        add_row(FN_CREATE, 16'h0000, 1'b1, R_FULL);
        // Join a live thread: yield away from the zombie slot 0, which stays
        // a zombie, and report waiting.
        add_row(FN_JOIN,   16'h0005, 1'b0, R_IDLE0);
        // Exit with others runnable, then join the fresh zombie to free it.
        add_row(FN_EXIT,   16'h0000, 1'b0, R_IDLE0);
        add_row(FN_JOIN,   16'h0001, 1'b0, R_IDLE0);
        // Join of the running thread itself also yields and waits.
        add_row(FN_JOIN,   16'h0002, 1'b0, R_IDLE0);
        // Create into the slot just freed, then a plain yield.
        add_row(FN_CREATE, 16'h0000, 1'b0, R_IDLE0);
        add_row(FN_YIELD,  16'h0000, 1'b0, R_IDLE0);

        foreach (dir_table[i])
            send_word(dir_table[i].op, dir_table[i].join_id,
                      dir_table[i].has_fixed, dir_table[i].fixed_res);

        // Random operations drawn against the live table: joins mostly name ids
        // that exist, with zero and arbitrary ids mixed in as noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op = FN_CREATE;
            else if (roll < 55)
                op = FN_YIELD;
            else if (roll < 80)
                op = FN_JOIN;
            else
                op = FN_EXIT;
            // join_tid carries random bits on every operation but join, which reads it.
            join_id = (op == FN_JOIN) ? pick_join_id() : 16'($urandom_range(0, 16'hFFFF));
            send_word(op, join_id, 1'b0, R_IDLE0);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        // Watch a while longer for any word the block should not send.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
